@@ src/rtxs_pkg.sv @@
// Package with the types, codes and reset values of the RTP transmit header sequencer.
package rtxs_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_SKIP = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] STATUS_HEADER = 2'd0;
    localparam logic [1:0] STATUS_NOT_READY = 2'd1;
    localparam logic [1:0] STATUS_NO_HEADER = 2'd2;

    localparam logic [2:0] REG_ENDPOINT_READY = 3'd0;
    localparam logic [2:0] REG_TS_QUANTUM = 3'd1;
    localparam logic [2:0] REG_TS_UNITS_PER_SEC = 3'd2;
    localparam logic [2:0] REG_NS_PER_TS_UNIT = 3'd3;
    localparam logic [2:0] REG_SOURCE_ID = 3'd4;
    localparam logic [2:0] REG_RTCP_INTERVAL = 3'd5;

    localparam logic [15:0] RESET_TS_QUANTUM = 16'd160;
    localparam logic [19:0] RESET_TS_UNITS_PER_SEC = 20'd8000;
    localparam logic [29:0] RESET_NS_PER_TS_UNIT = 30'd125000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_STAMP,
        ST_MOD,
        ST_NUDGE,
        ST_EMIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [6:0]  pt_value;
        logic        marker_in;
        logic        auto_mark;
        logic        force_rtcp;
        logic [31:0] now_seconds;
        logic [29:0] now_nanoseconds;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hdr_marker;
        logic [6:0]  hdr_payload_type;
        logic [15:0] hdr_sequence;
        logic [31:0] hdr_timestamp;
        logic [31:0] hdr_source;
        logic        rtcp_request;
        logic [31:0] rtcp_timestamp;
    } out_word_t;

endpackage

@@ src/rtxs_in_if.sv @@
// Handshake channel that carries one event word into the sequencer.
interface rtxs_in_if;
    logic valid;
    logic ready;
    rtxs_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/rtxs_out_if.sv @@
// Handshake channel that carries one header result word out of the sequencer.
interface rtxs_out_if;
    logic valid;
    logic ready;
    rtxs_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/rtp_tx_header_sequencer_unit.sv @@
// Top level of the RTP transmit header sequencer with its register file and shared divider.
//
// The block takes one event word at a time and answers each with exactly one result word.
// A skip, a restart request, an unused opcode and a rejected send pass from acceptance
// through decode and then the loading of the output register; a send on a running stream
// also builds the header between the two. The first send and the first send after a
// restart derive a timestamp from the wall clock: decode and multiplication, 32 steps of
// the shared restoring divider for the nanosecond part, forming the stamp, building the
// header and loading the output register. When a restart must test the clock distance
// for an exact quantum multiple, another 32 steps of the same divider and the nudge
// follow before the header is built. The event input is ready again once the result has
// moved into the output register; the output register holds a result while the sink
// stalls, and the input waits until that register is free.
module rtp_tx_header_sequencer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rtxs_pkg::ADDR_W-1:0] paddr,
    input  logic [rtxs_pkg::DATA_W-1:0] pwdata,
    output logic [rtxs_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    rtxs_in_if.sink                     evt,
    rtxs_out_if.source                  hdr
);

    rtxs_pkg::state_t state_reg, state_next;

    logic        endpoint_ready_reg;
    logic [15:0] ts_quantum_reg;
    logic [19:0] ts_units_per_sec_reg;
    logic [29:0] ns_per_ts_unit_reg;
    logic [31:0] source_id_reg;
    logic [15:0] rtcp_interval_reg;

    logic        started_reg, started_next;
    logic        pending_reg, pending_next;
    logic [15:0] seq_reg, seq_next;
    logic [31:0] ts_reg, ts_next;
    logic [15:0] rtcp_cnt_reg, rtcp_cnt_next;
    logic        out_valid_reg, out_valid_next;

    rtxs_pkg::in_word_t  cmd_reg;
    rtxs_pkg::out_word_t res_reg, res_next;
    rtxs_pkg::out_word_t out_data_reg, out_data_next;
    logic        mark_reg, mark_next;
    logic [31:0] prod_reg, prod_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [29:0] rem_reg, rem_next;
    logic [29:0] dsr_reg, dsr_next;
    logic [rtxs_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0] cts_reg, cts_next;

    logic        cfg_write;
    logic        accept;
    logic        out_free;
    logic        last_step;
    logic [30:0] shifted;
    logic        step_ge;
    logic [31:0] cts_w;
    logic [31:0] delta_w;
    logic [31:0] prod_w;
    logic [15:0] cnt_inc;
    logic        rtcp_hit;
    logic        rtcp_any;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign evt.ready = (state_reg == rtxs_pkg::ST_IDLE);
    assign accept = evt.valid && evt.ready;
    assign out_free = !out_valid_reg || hdr.ready;
    assign hdr.valid = out_valid_reg;
    assign hdr.data = out_data_reg;

    always_comb
    begin
        case (paddr[4:2])
            rtxs_pkg::REG_ENDPOINT_READY:   prdata = {31'd0, endpoint_ready_reg};
            rtxs_pkg::REG_TS_QUANTUM:       prdata = {16'd0, ts_quantum_reg};
            rtxs_pkg::REG_TS_UNITS_PER_SEC: prdata = {12'd0, ts_units_per_sec_reg};
            rtxs_pkg::REG_NS_PER_TS_UNIT:   prdata = {2'd0, ns_per_ts_unit_reg};
            rtxs_pkg::REG_SOURCE_ID:        prdata = source_id_reg;
            rtxs_pkg::REG_RTCP_INTERVAL:    prdata = {16'd0, rtcp_interval_reg};
            default:                        prdata = '0;
        endcase
    end

    // The shared unit performs one restoring division step per cycle.
    assign shifted = {rem_reg, dvd_reg[31]};
    assign step_ge = (shifted >= {1'b0, dsr_reg});
    assign last_step = (cnt_reg == rtxs_pkg::CNT_W'(rtxs_pkg::DIV_STEPS - 1));

    assign prod_w = cmd_reg.now_seconds * {12'd0, ts_units_per_sec_reg};
    assign cts_w = prod_reg + dvd_reg;
    assign delta_w = cts_w - ts_reg;
    assign cnt_inc = rtcp_cnt_reg + 16'd1;
    assign rtcp_hit = (rtcp_interval_reg != 16'd0) && (cnt_inc >= rtcp_interval_reg);
    assign rtcp_any = rtcp_hit || cmd_reg.force_rtcp;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtxs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = rtxs_pkg::ST_DECODE;
                end
            end
            rtxs_pkg::ST_DECODE:
            begin
                if (cmd_reg.opcode != rtxs_pkg::OP_SEND || !endpoint_ready_reg)
                begin
                    state_next = rtxs_pkg::ST_FINISH;
                end
                else if (!started_reg || pending_reg)
                begin
                    state_next = rtxs_pkg::ST_DIV;
                end
                else
                begin
                    state_next = rtxs_pkg::ST_EMIT;
                end
            end
            rtxs_pkg::ST_DIV:
            begin
                if (last_step)
                begin
                    state_next = rtxs_pkg::ST_STAMP;
                end
            end
            rtxs_pkg::ST_STAMP:
            begin
                if (started_reg && !(delta_w == 32'd0 || delta_w[31])
                    && ts_quantum_reg != 16'd0)
                begin
                    state_next = rtxs_pkg::ST_MOD;
                end
                else
                begin
                    state_next = rtxs_pkg::ST_EMIT;
                end
            end
            rtxs_pkg::ST_MOD:
            begin
                if (last_step)
                begin
                    state_next = rtxs_pkg::ST_NUDGE;
                end
            end
            rtxs_pkg::ST_NUDGE: state_next = rtxs_pkg::ST_EMIT;
            rtxs_pkg::ST_EMIT:  state_next = rtxs_pkg::ST_FINISH;
            rtxs_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = rtxs_pkg::ST_IDLE;
                end
            end
            default: state_next = rtxs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        started_next = started_reg;
        pending_next = pending_reg;
        seq_next = seq_reg;
        ts_next = ts_reg;
        rtcp_cnt_next = rtcp_cnt_reg;
        res_next = res_reg;
        mark_next = mark_reg;
        prod_next = prod_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        cts_next = cts_reg;
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg && !hdr.ready;

        case (state_reg)
            rtxs_pkg::ST_DECODE:
            begin
                res_next = '0;
                res_next.status = rtxs_pkg::STATUS_NO_HEADER;
                mark_next = cmd_reg.marker_in
                    || (cmd_reg.auto_mark && (!started_reg || pending_reg));
                prod_next = prod_w;
                dvd_next = {2'd0, cmd_reg.now_nanoseconds};
                rem_next = '0;
                dsr_next = (ns_per_ts_unit_reg == 30'd0) ? 30'd1 : ns_per_ts_unit_reg;
                cnt_next = '0;
                case (cmd_reg.opcode)
                    rtxs_pkg::OP_SKIP:
                    begin
                        if (started_reg && !pending_reg)
                        begin
                            ts_next = ts_reg + {16'd0, ts_quantum_reg};
                        end
                    end
                    rtxs_pkg::OP_RESTART: pending_next = 1'b1;
                    rtxs_pkg::OP_SEND:
                    begin
                        if (!endpoint_ready_reg)
                        begin
                            res_next.status = rtxs_pkg::STATUS_NOT_READY;
                        end
                    end
                    default: ;
                endcase
            end
            rtxs_pkg::ST_DIV, rtxs_pkg::ST_MOD:
            begin
                rem_next = step_ge ? 30'(shifted - {1'b0, dsr_reg}) : shifted[29:0];
                dvd_next = {dvd_reg[30:0], step_ge};
                cnt_next = cnt_reg + rtxs_pkg::CNT_W'(1);
            end
            rtxs_pkg::ST_STAMP:
            begin
                pending_next = 1'b0;
                cts_next = cts_w;
                dvd_next = delta_w;
                rem_next = '0;
                dsr_next = {14'd0, ts_quantum_reg};
                cnt_next = '0;
                if (!started_reg)
                begin
                    started_next = 1'b1;
                    ts_next = cts_w;
                end
                else if (delta_w == 32'd0 || delta_w[31])
                begin
                    ts_next = ts_reg + 32'd1;
                end
                else if (ts_quantum_reg == 16'd0)
                begin
                    ts_next = cts_w;
                end
            end
            rtxs_pkg::ST_NUDGE:
            begin
                ts_next = cts_reg + {31'd0, (rem_reg == 30'd0)};
            end
            rtxs_pkg::ST_EMIT:
            begin
                res_next.status = rtxs_pkg::STATUS_HEADER;
                res_next.hdr_marker = mark_reg;
                res_next.hdr_payload_type = cmd_reg.pt_value;
                res_next.hdr_sequence = seq_reg;
                res_next.hdr_timestamp = ts_reg;
                res_next.hdr_source = source_id_reg;
                res_next.rtcp_request = rtcp_any;
                res_next.rtcp_timestamp = rtcp_any ? ts_reg : 32'd0;
                seq_next = seq_reg + 16'd1;
                ts_next = ts_reg + {16'd0, ts_quantum_reg};
                if (rtcp_interval_reg != 16'd0)
                begin
                    rtcp_cnt_next = rtcp_hit ? 16'd0 : cnt_inc;
                end
            end
            rtxs_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_data_next = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtxs_pkg::ST_IDLE;
            endpoint_ready_reg <= 1'b0;
            ts_quantum_reg <= rtxs_pkg::RESET_TS_QUANTUM;
            ts_units_per_sec_reg <= rtxs_pkg::RESET_TS_UNITS_PER_SEC;
            ns_per_ts_unit_reg <= rtxs_pkg::RESET_NS_PER_TS_UNIT;
            source_id_reg <= '0;
            rtcp_interval_reg <= '0;
            started_reg <= 1'b0;
            pending_reg <= 1'b0;
            seq_reg <= '0;
            ts_reg <= '0;
            rtcp_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            started_reg <= started_next;
            pending_reg <= pending_next;
            seq_reg <= seq_next;
            ts_reg <= ts_next;
            rtcp_cnt_reg <= rtcp_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (paddr[4:2])
                    rtxs_pkg::REG_ENDPOINT_READY:   endpoint_ready_reg <= pwdata[0];
                    rtxs_pkg::REG_TS_QUANTUM:       ts_quantum_reg <= pwdata[15:0];
                    rtxs_pkg::REG_TS_UNITS_PER_SEC: ts_units_per_sec_reg <= pwdata[19:0];
                    rtxs_pkg::REG_NS_PER_TS_UNIT:   ns_per_ts_unit_reg <= pwdata[29:0];
                    rtxs_pkg::REG_SOURCE_ID:        source_id_reg <= pwdata;
                    rtxs_pkg::REG_RTCP_INTERVAL:    rtcp_interval_reg <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= evt.data;
        end
        res_reg <= res_next;
        mark_reg <= mark_next;
        prod_reg <= prod_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
        cts_reg <= cts_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ src/rtxs_checker.sv @@
// Port-level checker for the RTP transmit header sequencer and its bind to the top level.
module rtxs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                evt_valid,
    input logic                evt_ready,
    input logic                hdr_valid,
    input logic                hdr_ready,
    input rtxs_pkg::out_word_t hdr_data
);

    // A stalled result word holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid && !hdr_ready |=> hdr_valid && $stable(hdr_data))
    else $error("result word changed while stalled");

    // Only one event word is in work at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |=> !evt_ready)
    else $error("event accepted while another is in work");

    // A word without a header carries nothing but its status.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid && hdr_data.status != rtxs_pkg::STATUS_HEADER |->
        !hdr_data.hdr_marker && hdr_data.hdr_payload_type == 7'd0
        && hdr_data.hdr_sequence == 16'd0 && hdr_data.hdr_timestamp == 32'd0
        && hdr_data.hdr_source == 32'd0 && !hdr_data.rtcp_request
        && hdr_data.rtcp_timestamp == 32'd0)
    else $error("result without header has nonzero fields");

    // The report timestamp is that of the header just produced.
    a_rtcp_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_valid && hdr_data.rtcp_request |->
        hdr_data.rtcp_timestamp == hdr_data.hdr_timestamp)
    else $error("report timestamp differs from header timestamp");

endmodule

bind rtp_tx_header_sequencer_unit rtxs_checker u_rtxs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .hdr_valid (hdr.valid),
    .hdr_ready (hdr.ready),
    .hdr_data  (hdr.data)
);
